### rtl/clock_stopwatch_display_assert.svh
// assertion macros for the clock and stopwatch display block
// used by the port checker; no other dependencies
`ifndef CLOCK_STOPWATCH_DISPLAY_ASSERT_SVH
`define CLOCK_STOPWATCH_DISPLAY_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clock stopwatch display: assertion failed");

// next-cycle implication, disabled in reset
`define CSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clock stopwatch display: assertion failed");

`endif

### rtl/clkswd_pkg.sv
// shared types, codes and segment decode for the clock and stopwatch display
// no dependencies
package clkswd_pkg;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } bcd_type;

   localparam bcd_type HUND_LAST  = '{tens: 4'd9, units: 4'd9};
   localparam bcd_type SIXTY_LAST = '{tens: 4'd5, units: 4'd9};
   localparam bcd_type HOUR_LAST  = '{tens: 4'd2, units: 4'd3};
   localparam bcd_type ZERO_INIT  = '{tens: 4'd0, units: 4'd0};
   localparam bcd_type HOUR_INIT  = '{tens: 4'd1, units: 4'd5};
   localparam bcd_type MIN_INIT   = '{tens: 4'd4, units: 4'd5};

   // segments a..g in bits 0..6, bit 7 clear
   function automatic logic [7:0] seg_byte(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7C;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h67;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic logic [15:0] seg_pair(input bcd_type value);
      return {seg_byte(value.tens), seg_byte(value.units)};
   endfunction

endpackage

### rtl/clock_stopwatch_display.sv
// clock_stopwatch_display: time of day and stopwatch on four segment digits
// depends on clkswd_pkg, clkswd_cell, clkswd_mode
//
// each request is one hundredth-second tick with the button and switch bits.
// the clock advances one hundredth through a chain of bcd counter cells
// (hundredths, seconds, minutes, hours); the stopwatch has its own two cells
// that count only while running. every request gives one response word:
// hours:minutes when all switches are off, stopwatch seconds:hundredths else.
// the response word is registered, in the skid register if the response
// register holds a word not taken. throughput: one request per cycle while
// req_stall is low; the carry chain and segment decode are combinational.
// a response register and a one-entry skid register sit on the output, so a
// request is taken while one response waits; req_stall rises only when both
// hold a word and falls once the receiver takes one.
// reset (synchronous) sets the clock to 15:45:00.00, the stopwatch to idle
// with zero counts, and empties the output registers.
module clock_stopwatch_display
   import clkswd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_buttons,
   input  logic [9:0]  req_switch_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_display_word
);

   logic    accept;
   logic    take;
   logic    running;
   logic    c_hund, c_sec, c_min, c_hour, w_hund, w_sec;
   bcd_type hund_next, sec_next, min_next, hour_next;
   bcd_type whund_next, wsec_next;
   logic [31:0] word;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_word_ff, skid_word_in;

   assign accept = req_valid & ~req_stall;
   assign take   = out_valid_ff & ~rsp_stall;

   // clock chain
   clkswd_cell u_hund (.clock, .reset, .init_value(ZERO_INIT), .last_value(HUND_LAST),
      .carry_in(accept), .carry_out(c_hund), .next_value(hund_next));
   clkswd_cell u_sec (.clock, .reset, .init_value(ZERO_INIT), .last_value(SIXTY_LAST),
      .carry_in(c_hund), .carry_out(c_sec), .next_value(sec_next));
   clkswd_cell u_min (.clock, .reset, .init_value(MIN_INIT), .last_value(SIXTY_LAST),
      .carry_in(c_sec), .carry_out(c_min), .next_value(min_next));
   clkswd_cell u_hour (.clock, .reset, .init_value(HOUR_INIT), .last_value(HOUR_LAST),
      .carry_in(c_min), .carry_out(c_hour), .next_value(hour_next));

   // stopwatch chain
   clkswd_mode u_mode (.clock, .reset, .tick(accept), .buttons(req_buttons),
      .running(running));
   clkswd_cell u_whund (.clock, .reset, .init_value(ZERO_INIT), .last_value(HUND_LAST),
      .carry_in(running), .carry_out(w_hund), .next_value(whund_next));
   clkswd_cell u_wsec (.clock, .reset, .init_value(ZERO_INIT), .last_value(SIXTY_LAST),
      .carry_in(w_hund), .carry_out(w_sec), .next_value(wsec_next));

   // wrap of the last cells has no further stage
   logic unused_carry;
   assign unused_carry = c_hour ^ w_sec;

   assign word = (req_switch_bits == 10'd0) ? {seg_pair(hour_next), seg_pair(min_next)}
                                            : {seg_pair(wsec_next), seg_pair(whund_next)};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_word_in  = word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = word;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign req_stall        = skid_valid_ff | (unused_carry & 1'b0);
   assign rsp_valid        = out_valid_ff;
   assign rsp_display_word = out_word_ff;

endmodule

### rtl/clkswd_cell.sv
// one two-digit bcd counter cell of the carry chain
// depends on clkswd_pkg
module clkswd_cell
   import clkswd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  bcd_type init_value,
   input  bcd_type last_value,
   input  logic    carry_in,
   output logic    carry_out,
   output bcd_type next_value
);

   bcd_type value_ff;
   bcd_type value_in;
   logic    at_last;

   assign at_last = (value_ff == last_value);

   always_comb begin
      value_in = value_ff;
      if (carry_in) begin
         if (at_last) begin
            value_in = ZERO_INIT;
         end else if (value_ff.units == 4'd9) begin
            value_in.tens  = value_ff.tens + 4'd1;
            value_in.units = 4'd0;
         end else begin
            value_in.units = value_ff.units + 4'd1;
         end
      end
   end

   assign carry_out  = carry_in & at_last;
   assign next_value = value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= init_value;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

### rtl/clkswd_mode.sv
// stopwatch mode register and button handling
// depends on clkswd_pkg
module clkswd_mode
   import clkswd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick,
   input  logic [3:0] buttons,
   output logic       running
);

   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic [1:0] mode_tmp;

   always_comb begin
      mode_tmp = mode_ff;
      if (buttons[1] && mode_tmp == MODE_IDLE) begin
         mode_tmp = MODE_RUN;
      end
      if (buttons[2]) begin
         mode_tmp = (mode_tmp == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
      end
      if (buttons[3] && mode_tmp == MODE_RUN) begin
         mode_tmp = MODE_IDLE;
      end
      mode_in = tick ? mode_tmp : mode_ff;
   end

   assign running = tick && (mode_tmp == MODE_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

### rtl/clkswd_checker.sv
// port checker for clock_stopwatch_display, attached by bind
// depends on clock_stopwatch_display_assert.svh
`include "clock_stopwatch_display_assert.svh"

module clkswd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [3:0]  req_buttons,
   input logic [9:0]  req_switch_bits,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_display_word
);

   logic unused_in;
   assign unused_in = ^{req_buttons, req_switch_bits};

   `CSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_display_word))
   `CSD_ASSERT_NOW(a_bit7_clear, clock, reset, rsp_valid, (rsp_display_word & 32'h80808080) == 32'h0)
   `CSD_ASSERT_NOW(a_stall_full, clock, reset, req_stall, rsp_valid)
   `CSD_ASSERT_NEXT(a_req_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

endmodule

bind clock_stopwatch_display clkswd_checker u_checker (.*);
